// ----- hw/rtl/flow_shop_makespan_core_macros.svh -----
// Assertion macros used by the flow shop makespan cell RTL.
`ifndef FLOW_SHOP_MAKESPAN_CORE_MACROS_SVH
`define FLOW_SHOP_MAKESPAN_CORE_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled during reset.
`define FSMK_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("flow shop assertion failed");

// Next-cycle implication, disabled during reset.
`define FSMK_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("flow shop assertion failed");

`else

`define FSMK_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define FSMK_ASSERT_NXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ----- hw/rtl/fsmk_pkg.sv -----
// Types and constants shared by the flow shop makespan core and its cells.
`timescale 1ns / 1ps
package fsmk_pkg;

  localparam int TIME_W           = 16;
  localparam int SPAN_W           = 32;
  localparam int TIME_FIELDS      = 8;
  localparam int CNT_W            = 4;
  localparam int DEF_MAX_MACHINES = 8;
  localparam logic [CNT_W-1:0] MACH_RESET = 4'd8;

  typedef logic [TIME_W-1:0] time_t;
  typedef logic [SPAN_W-1:0] span_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  // Processing times still ahead of a job; entry 0 belongs to the next cell.
  typedef logic [TIME_FIELDS-1:0][TIME_W-1:0] times_t;

  // What one cell hands to its neighbor along with the job.
  typedef struct packed {
    logic  vld;
    logic  clr;
    logic  sat;
    cnt_t  rem;
    span_t span;
  } link_t;

endpackage

// ----- hw/rtl/flow_shop_makespan_core.sv -----
// An accepted request passes the output register of every cell in turn.
// Throughput: one request per cycle; each cell updates its machine's ready time
// once per job as the wavefront passes, so jobs follow each other back to back.
// The whole chain holds while a result waits under out_stall.
// Reset clears all ready times and valid flags and sets machine_count to 8.
`timescale 1ns / 1ps
module flow_shop_makespan_core
  import fsmk_pkg::*;
#(
  parameter int MAX_MACHINES = DEF_MAX_MACHINES
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CNT_W-1:0]  cfg_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              start_new,
  input  logic [TIME_W-1:0] time_0,
  input  logic [TIME_W-1:0] time_1,
  input  logic [TIME_W-1:0] time_2,
  input  logic [TIME_W-1:0] time_3,
  input  logic [TIME_W-1:0] time_4,
  input  logic [TIME_W-1:0] time_5,
  input  logic [TIME_W-1:0] time_6,
  input  logic [TIME_W-1:0] time_7,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [SPAN_W-1:0] makespan_so_far,
  output logic              saturated
);

  cnt_t   machine_count;
  cnt_t   used_count;
  logic   adv;
  link_t  lnk [MAX_MACHINES+1];
  times_t tms [MAX_MACHINES+1];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      machine_count <= MACH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      machine_count <= cfg_data;
    end
  end

  // A count of zero means one machine; anything past the chain length is capped.
  always_comb begin
    if (machine_count == '0) begin
      used_count = cnt_t'(1);
    end else if (machine_count > cnt_t'(MAX_MACHINES)) begin
      used_count = cnt_t'(MAX_MACHINES);
    end else begin
      used_count = machine_count;
    end
  end

  assign adv      = !(lnk[MAX_MACHINES].vld && out_stall);
  assign in_stall = !adv;

  always_comb begin
    lnk[0].vld  = in_valid;
    lnk[0].clr  = start_new;
    lnk[0].sat  = 1'b0;
    lnk[0].rem  = used_count;
    lnk[0].span = '0;
    tms[0]      = {time_7, time_6, time_5, time_4, time_3, time_2, time_1, time_0};
  end

  for (genvar k = 0; k < MAX_MACHINES; k++) begin : g_cell
    fsmk_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .adv  (adv),
      .lin  (lnk[k]),
      .tin  (tms[k]),
      .lout (lnk[k+1]),
      .tout (tms[k+1])
    );
  end

  assign out_valid       = lnk[MAX_MACHINES].vld;
  assign makespan_so_far = lnk[MAX_MACHINES].span;
  assign saturated       = lnk[MAX_MACHINES].sat;

endmodule

// ----- hw/rtl/fsmk_cell.sv -----
// One machine of the flow shop chain: holds its ready time and places each passing job.
`timescale 1ns / 1ps
`include "flow_shop_makespan_core_macros.svh"
module fsmk_cell
  import fsmk_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   adv,
  input  link_t  lin,
  input  times_t tin,
  output link_t  lout,
  output times_t tout
);

  span_t               ready;
  span_t               base;
  span_t               start;
  span_t               done;
  logic [SPAN_W:0]     sum;
  logic                used;
  logic                clip;
  cnt_t                rem_next;
  link_t               lout_q;
  times_t              tout_q;

  always_comb begin
    // A new schedule sees every machine free at time zero.
    base     = lin.clr ? '0 : ready;
    start    = (base > lin.span) ? base : lin.span;
    sum      = {1'b0, start} + {{(SPAN_W + 1 - TIME_W){1'b0}}, tin[0]};
    used     = (lin.rem != '0);
    clip     = sum[SPAN_W];
    done     = clip ? '1 : sum[SPAN_W-1:0];
    rem_next = used ? (lin.rem - cnt_t'(1)) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ready      <= '0;
      lout_q.vld <= 1'b0;
    end else if (adv) begin
      lout_q.vld  <= lin.vld;
      lout_q.clr  <= lin.clr;
      lout_q.sat  <= lin.sat | (used & clip);
      lout_q.rem  <= rem_next;
      lout_q.span <= used ? done : lin.span;
      tout_q      <= {time_t'(0), tin[TIME_FIELDS-1:1]};
      if (lin.vld) begin
        ready <= used ? done : base;
      end
    end
  end

  assign lout = lout_q;
  assign tout = tout_q;

  // Once a completion has clipped, every later completion of that job is clipped too.
  `FSMK_ASSERT_IMP(a_sat_top, clk, rst, lout_q.vld && lout_q.sat, lout_q.span == '1)
  // A machine beyond the used count keeps its ready time unless a new schedule starts.
  `FSMK_ASSERT_NXT(a_unused_hold, clk, rst,
                   adv && lin.vld && (lin.rem == '0) && !lin.clr, $stable(ready))
  // A job never completes on a used machine before it completed on the previous one.
  `FSMK_ASSERT_NXT(a_done_order, clk, rst,
                   adv && lin.vld && (lin.rem != '0), lout_q.span >= $past(lin.span))

endmodule
